// File: hdl/cbp_pkg.sv
package cbp_pkg;

    // Default geometry: table rows come from address bits, columns from history
    localparam int CBP_ADDR_BITS_DEF = 10;
    localparam int CBP_HIST_BITS_DEF = 2;

    // Two-bit hysteresis counter codes
    typedef logic [1:0] t_ctr;

    localparam t_ctr CTR_STRONG_T  = 2'b11;
    localparam t_ctr CTR_WEAK_T    = 2'b10;
    localparam t_ctr CTR_WEAK_NT   = 2'b01;
    localparam t_ctr CTR_STRONG_NT = 2'b00;

    // Write request into the counter table (address travels beside it)
    typedef struct packed {
        logic en;
        t_ctr data;
    } t_tbl_wr;

    // Counter update: a weak counter jumps to the strong state of the outcome
    function automatic t_ctr next_counter(input t_ctr c, input logic taken);
        t_ctr n;
        case (c)
            CTR_STRONG_T: n = taken ? CTR_STRONG_T : CTR_WEAK_T;
            CTR_WEAK_T:   n = taken ? CTR_STRONG_T : CTR_STRONG_NT;
            CTR_WEAK_NT:  n = taken ? CTR_STRONG_T : CTR_STRONG_NT;
            default:      n = taken ? CTR_WEAK_NT  : CTR_STRONG_NT;
        endcase
        return n;
    endfunction

endpackage

// File: hdl/cbp_table.sv
module cbp_table
    import cbp_pkg::*;
#(
    parameter int IDX_W = CBP_ADDR_BITS_DEF + CBP_HIST_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_idx,
    output t_ctr             o_rd_data,
    input  t_tbl_wr          i_wr,
    input  logic [IDX_W-1:0] i_wr_idx,
    output logic             o_clearing
);

    localparam int DEPTH = 1 << IDX_W;

    t_ctr             r_mem [DEPTH];
    t_ctr             r_rd_data;
    logic             r_clearing;
    logic [IDX_W-1:0] r_clr_idx;

    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    t_ctr             w_wdata;

    // Clearing pass after reset: one entry per cycle to strongly taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == IDX_W'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Write port is owned by the sweep while clearing
    assign w_we    = r_clearing | i_wr.en;
    assign w_waddr = r_clearing ? r_clr_idx : i_wr_idx;
    assign w_wdata = r_clearing ? CTR_STRONG_T : i_wr.data;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    // Registered read; data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule

// File: hdl/correlating_branch_predictor.sv
// Correlating branch predictor, one resolved branch per beat. The table row is the low
// ADDRESS_INDEX_BITS of the branch address, the column the HISTORY_BITS global history
// (newest outcome in the MSB). Sustained rate is one branch per clock while the output
// is not stalled. The table read is registered at the accepting edge together with the
// update stage; the counter update there writes back at the same edge at which the
// result is registered in the output register. A branch that hits the entry written
// by the branch just ahead of it gets the updated counter by forwarding. After reset
// the table is swept to strongly taken, one entry per cycle, over all
// 2^(ADDRESS_INDEX_BITS+HISTORY_BITS) entries (4096 by default);
// o_in_stall stays high until the sweep ends.
module correlating_branch_predictor
    import cbp_pkg::*;
#(
    parameter int ADDRESS_INDEX_BITS = CBP_ADDR_BITS_DEF,
    parameter int HISTORY_BITS       = CBP_HIST_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_branch_address,
    input  logic        i_outcome,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_prediction
);

    localparam int IDX_W = ADDRESS_INDEX_BITS + HISTORY_BITS;

    logic [HISTORY_BITS-1:0] r_hist;
    logic [HISTORY_BITS-1:0] n_hist;
    logic [HISTORY_BITS:0]   w_hist_cat;

    logic             r_s1_valid;
    logic [IDX_W-1:0] r_s1_idx;
    logic             r_s1_taken;
    logic             r_s1_fwd;
    t_ctr             r_s1_fwd_ctr;

    logic             r_out_valid;
    logic             r_prediction;

    logic             w_accept;
    logic             w_s1_fire;
    logic             w_clearing;
    logic [IDX_W-1:0] w_rd_idx;
    t_ctr             w_rd_data;
    t_ctr             w_s1_ctr;
    t_ctr             w_s1_next;
    t_tbl_wr          w_wr;

    // Handshake
    assign w_s1_fire  = r_s1_valid & (~r_out_valid | ~i_out_stall);
    assign o_in_stall = w_clearing | (r_s1_valid & ~w_s1_fire);
    assign w_accept   = i_in_valid & ~o_in_stall;

    // Lookup index and history shift
    assign w_rd_idx   = {i_branch_address[ADDRESS_INDEX_BITS-1:0], r_hist};
    assign w_hist_cat = {i_outcome, r_hist};
    assign n_hist     = w_hist_cat[HISTORY_BITS:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '1;
        end else if (w_accept) begin
            r_hist <= n_hist;
        end
    end

    // Counter table
    cbp_table #(
        .IDX_W (IDX_W)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_accept),
        .i_rd_idx   (w_rd_idx),
        .o_rd_data  (w_rd_data),
        .i_wr       (w_wr),
        .i_wr_idx   (r_s1_idx),
        .o_clearing (w_clearing)
    );

    // Update stage: forward the counter written in the read cycle
    assign w_s1_ctr  = r_s1_fwd ? r_s1_fwd_ctr : w_rd_data;
    assign w_s1_next = next_counter(w_s1_ctr, r_s1_taken);
    assign w_wr.en   = w_s1_fire;
    assign w_wr.data = w_s1_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_idx     <= w_rd_idx;
            r_s1_taken   <= i_outcome;
            r_s1_fwd     <= w_s1_fire & (r_s1_idx == w_rd_idx);
            r_s1_fwd_ctr <= w_s1_next;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (~i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_fire) begin
            r_prediction <= w_s1_ctr[1];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_prediction = r_prediction;

endmodule

// File: hdl/cbp_checker.sv
module cbp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [31:0] i_branch_address,
    input logic        i_outcome,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_prediction
);

    logic w_in_beat;
    assign w_in_beat = i_in_valid & ~o_in_stall;

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_prediction)))
        else $error("stalled result changed");

    // Table is swept right after reset, so no beat is taken then
    a_clear_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> o_in_stall)
        else $error("input taken during clearing pass");

    // A beat moves to the output once the output register frees up
    a_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat ##1 (!o_out_valid || !i_out_stall) |=> o_out_valid)
        else $error("accepted branch did not reach the output");

    // Pipeline full behind a stalled output: no further beat
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_beat && o_out_valid && i_out_stall) ##1 i_out_stall |-> o_in_stall)
        else $error("input taken with pipeline full");

endmodule

bind correlating_branch_predictor cbp_checker u_cbp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .i_branch_address (i_branch_address),
    .i_outcome        (i_outcome),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_prediction     (o_prediction)
);

// File: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import cbp_pkg::*;

    localparam int ADDR_BITS     = CBP_ADDR_BITS_DEF;
    localparam int HIST_BITS     = CBP_HIST_BITS_DEF;
    localparam int TABLE_ENTRIES = 1 << (ADDR_BITS + HIST_BITS);
    localparam int LONG_HOLD     = 300;
    // reset sweep plus the long hold, with plenty of margin
    localparam int WATCHDOG_LIMIT = 5 * TABLE_ENTRIES + 4 * LONG_HOLD;
    localparam int POOL_SIZE     = 8;
    localparam logic [31:0] ROW_MASK = 32'((1 << ADDR_BITS) - 1);

    typedef struct packed {
        logic [31:0] addr;
        logic        taken;
    } branch_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [31:0] branch_addr = '0;
    logic        branch_taken = 1'b0;
    logic        out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_prediction;

    // stimulus and scoreboard
    branch_t pending_branches[$];
    logic    predicted_dirs[$];
    t_ctr    pred_table[TABLE_ENTRIES];
    logic [HIST_BITS-1:0] path_history;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int holds_wanted  = 0;
    int holds_done    = 0;
    int hold_left     = 0;
    logic in_fired    = 1'b0;

    int error_count     = 0;
    int branches_sent   = 0;
    int preds_checked   = 0;
    int idle_cycles     = 0;

    // hot branch pool: each entry behaves like a loop branch of some trip count
    logic [31:0] pool_addr[POOL_SIZE];
    int          pool_trip[POOL_SIZE];
    int          pool_iter[POOL_SIZE];

    correlating_branch_predictor #(
        .ADDRESS_INDEX_BITS (ADDR_BITS),
        .HISTORY_BITS       (HIST_BITS)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (o_in_stall),
        .i_branch_address (branch_addr),
        .i_outcome        (branch_taken),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .o_prediction     (o_prediction)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic exp_dir, input logic got_dir);
        $display("MISMATCH @%0t: %s expected %b got %b (prediction #%0d)",
                 $realtime, what, exp_dir, got_dir, preds_checked);
        error_count++;
    endtask

    // hysteresis update: a weak counter jumps to the strong state of the outcome
    function automatic t_ctr bump_counter(input t_ctr c, input logic taken);
        if (taken)
            return (c == CTR_STRONG_NT) ? CTR_WEAK_NT : CTR_STRONG_T;
        else
            return (c == CTR_STRONG_T) ? CTR_WEAK_T : CTR_STRONG_NT;
    endfunction

    // look up, record the expected direction, then train table and history
    task automatic predict_branch(input logic [31:0] addr, input logic taken);
        int   idx;
        t_ctr c;
        idx = int'({addr[ADDR_BITS-1:0], path_history});
        c = pred_table[idx];
        predicted_dirs.push_back(c[1]);
        pred_table[idx] = bump_counter(c, taken);
        path_history = (path_history >> 1) | (HIST_BITS'(taken) << (HIST_BITS - 1));
    endtask

    task automatic add_branch(input logic [31:0] addr, input logic taken);
        branch_t b;
        b.addr  = addr;
        b.taken = taken;
        pending_branches.push_back(b);
    endtask

    // mostly loop-like traffic on a few hot branches, some aliasing, some noise
    task automatic add_random_branch();
        int   r;
        int   p;
        logic t;
        r = $urandom_range(99);
        p = $urandom_range(POOL_SIZE - 1);
        t = (pool_iter[p] % pool_trip[p]) != (pool_trip[p] - 1);
        if (r < 70) begin
            pool_iter[p]++;
            if ($urandom_range(9) == 0)
                t = ~t;
            add_branch(pool_addr[p], t);
        end else if (r < 85) begin
            // same row, different upper address bits
            add_branch(($urandom() & ~ROW_MASK) | (pool_addr[p] & ROW_MASK),
                       1'($urandom_range(1)));
        end else begin
            add_branch($urandom(), 1'($urandom_range(1)));
        end
    endtask

    // driver: next beat goes out at the falling edge once the last one was taken
    always @(negedge i_clk) begin : drive_beat
        branch_t b;
        if (i_rst_n && (!in_valid || in_fired)) begin
            if (pending_branches.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                b = pending_branches.pop_front();
                branch_addr  <= b.addr;
                branch_taken <= b.taken;
                in_valid     <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver stall: random, or a long hold when one is requested
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (holds_done < holds_wanted) begin
            holds_done <= holds_done + 1;
            hold_left  <= LONG_HOLD;
            out_stall  <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // monitor: predict accepted branches, check accepted predictions
    always @(posedge i_clk) begin
        in_fired <= i_rst_n && in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (o_out_valid && !out_stall) begin
                if (predicted_dirs.size() == 0)
                    report_mismatch("unexpected prediction", 1'bx, o_prediction);
                else if (o_prediction !== predicted_dirs[0])
                    report_mismatch("prediction", predicted_dirs[0], o_prediction);
                if (predicted_dirs.size() > 0)
                    void'(predicted_dirs.pop_front());
                preds_checked++;
            end
            if (in_valid && !o_in_stall) begin
                predict_branch(branch_addr, branch_taken);
                branches_sent++;
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no beat for %0d cycles", idle_cycles);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_branches.size() > 0 || in_valid || predicted_dirs.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int n,
                             input bit with_hold);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < n; i++) begin
            add_random_branch();
            // hold the output while the sender keeps offering
            if (with_hold && i == n / 2)
                holds_wanted++;
        end
        wait_drained();
    endtask

    initial begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
            pred_table[i] = CTR_STRONG_T;
        path_history = '1;
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_addr[i] = $urandom();
            pool_trip[i] = $urandom_range(1, 7);
            pool_iter[i] = 0;
        end
        // two hot branches sharing a row
        pool_addr[1][ADDR_BITS-1:0] = pool_addr[0][ADDR_BITS-1:0];

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: address extremes, upper bits ignored, back-to-back same entry
        add_branch(32'h0000_0000, 1'b1);
        add_branch(32'hFFFF_FFFF, 1'b0);
        add_branch(32'hFFFF_FC00, 1'b0);
        add_branch(32'h0000_03FF, 1'b1);
        add_branch(32'h1234_5678, 1'b1);
        repeat (5) add_branch(32'h0000_0155, 1'b0);
        repeat (5) add_branch(32'h0000_0155, 1'b1);
        for (int i = 0; i < 4; i++)
            add_branch(32'hA5A5_02AA, 1'(i % 2));
        wait_drained();

        // sender pauses between phases until every prediction is back
        run_phase(24, 60, 500, 1'b1);
        run_phase(60, 24, 500, 1'b0);
        run_phase(0, 0, 500, 1'b1);

        repeat (16) @(posedge i_clk);
        if (predicted_dirs.size() != 0)
            report_mismatch("missing prediction", predicted_dirs[0], 1'bx);

        $display("Ran %0d resolved branches, %0d predictions checked,", branches_sent,
                 preds_checked);
        $display("with loop-like, aliased and random traffic under three stall mixes.");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/cbp_pkg.sv
hdl/cbp_table.sv
hdl/correlating_branch_predictor.sv
hdl/cbp_checker.sv
dv/tb_top.sv
